// ===== hdl/sapq_pkg.sv =====
// ----------------------------------------------------------------------------
// sapq_pkg: shared types and codes of the sorted-array priority queue
// Entry layout, operation and status codes, default queue depth.
// ----------------------------------------------------------------------------
package sapq_pkg;

  localparam int SAPQ_DEPTH = 8;

  localparam int TAG_W  = 32;
  localparam int PRIO_W = 16;
  localparam int KEY_W  = 8;
  localparam int ENTRY_W = TAG_W + PRIO_W + KEY_W;

  // Packed so that the tag sits in the lowest bits, as on the stream ports.
  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [PRIO_W-1:0] prio;
    logic [TAG_W-1:0]  tag;
  } entry_t;

  typedef logic [1:0] status_t;

  localparam logic    OP_PUSH  = 1'b0;
  localparam logic    OP_POP   = 1'b1;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_FULL  = 2'd1;
  localparam status_t ST_EMPTY = 2'd2;

endpackage

// ===== hdl/sapq_store.sv =====
// ----------------------------------------------------------------------------
// sapq_store: entry memory of the priority queue
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sapq_store #(
  parameter int DEPTH = sapq_pkg::SAPQ_DEPTH,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  sapq_pkg::entry_t wdata,
  input  logic [AW-1:0]   raddr,
  output sapq_pkg::entry_t rdata
);
  import sapq_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/sapq_cmp.sv =====
// ----------------------------------------------------------------------------
// sapq_cmp: ordering compare of two queue entries
// Tells whether entry a must be served strictly before entry b.
// ----------------------------------------------------------------------------
module sapq_cmp (
  input  sapq_pkg::entry_t a,
  input  sapq_pkg::entry_t b,
  output logic             a_first
);
  import sapq_pkg::*;

  // Lower priority wins; equal priorities fall back to the lower order key.
  always_comb begin
    if (a.prio != b.prio) begin
      a_first = (a.prio < b.prio);
    end else begin
      a_first = (a.key < b.key);
    end
  end

endmodule

// ===== hdl/sorted_array_priority_queue.sv =====
// Throughput: one beat at a time; the single memory port pair moves one entry a cycle.
// Reset (synchronous, active low) empties the queue; memory contents are not cleared.
// ----------------------------------------------------------------------------
// sorted_array_priority_queue: bounded priority queue kept in sorted order
// Push inserts by shifting larger entries up one slot a cycle; pop returns the
// head and shifts the rest down. One result beat follows every input beat.
// ----------------------------------------------------------------------------
module sorted_array_priority_queue #(
  parameter int DEPTH = sapq_pkg::SAPQ_DEPTH
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [sapq_pkg::ENTRY_W-1:0] in_tdata,   // job_tag, priority_req, order_key
  input  logic                         in_tuser,   // op
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [sapq_pkg::ENTRY_W-1:0] out_tdata,  // out_job_tag, out_priority,
                                                   // out_order_key
  output logic [1:0]                   out_tuser   // status
);
  import sapq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
  localparam logic [CW-1:0] ONE      = CW'(1);
  localparam logic [CW-1:0] TWO      = CW'(2);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_PCMP   = 3'd1;
  localparam logic [2:0] S_PFIN   = 3'd2;
  localparam logic [2:0] S_QHEAD  = 3'd3;
  localparam logic [2:0] S_QSHIFT = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] occ_r, occ_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  entry_t        item_r, item_nxt;
  status_t       res_stat_r, res_stat_nxt;
  entry_t        res_data_r, res_data_nxt;
  logic          out_valid_r, out_valid_nxt;
  status_t       out_stat_r, out_stat_nxt;
  entry_t        out_data_r, out_data_nxt;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  entry_t        mem_wdata;
  logic [AW-1:0] mem_raddr;
  entry_t        mem_rdata;
  logic          item_first;
  logic [CW-1:0] cnt_m1, cnt_m2, cnt_p1, occ_m1;

  sapq_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  sapq_cmp u_cmp (
    .a       (item_r),
    .b       (mem_rdata),
    .a_first (item_first)
  );

  assign in_tready = (state_r == S_IDLE);
  assign cnt_m1 = cnt_r - ONE;
  assign cnt_m2 = cnt_r - TWO;
  assign cnt_p1 = cnt_r + ONE;
  assign occ_m1 = occ_r - ONE;

  always_comb begin
    state_nxt     = state_r;
    occ_nxt       = occ_r;
    cnt_nxt       = cnt_r;
    item_nxt      = item_r;
    res_stat_nxt  = res_stat_r;
    res_data_nxt  = res_data_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    out_stat_nxt  = out_stat_r;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = item_r;
    mem_raddr     = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          item_nxt     = entry_t'(in_tdata);
          res_stat_nxt = ST_OK;
          res_data_nxt = '0;
          if (in_tuser == OP_PUSH) begin
            if (occ_r == FULL_CNT) begin
              res_stat_nxt = ST_FULL;
              state_nxt    = S_DONE;
            end else if (occ_r == '0) begin
              mem_we    = 1'b1;
              mem_wdata = entry_t'(in_tdata);
              occ_nxt   = ONE;
              state_nxt = S_DONE;
            end else begin
              cnt_nxt   = occ_r;
              mem_raddr = occ_m1[AW-1:0];
              state_nxt = S_PCMP;
            end
          end else begin
            if (occ_r == '0) begin
              res_stat_nxt = ST_EMPTY;
              state_nxt    = S_DONE;
            end else begin
              cnt_nxt   = ONE;
              state_nxt = S_QHEAD;
            end
          end
        end
      end

      // The entry below the insertion point is on the read data; move it up or
      // drop the new entry in behind it.
      S_PCMP: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_r[AW-1:0];
        if (item_first) begin
          mem_wdata = mem_rdata;
          cnt_nxt   = cnt_m1;
          if (cnt_r == ONE) begin
            state_nxt = S_PFIN;
          end else begin
            mem_raddr = cnt_m2[AW-1:0];
          end
        end else begin
          occ_nxt   = occ_r + ONE;
          state_nxt = S_DONE;
        end
      end

      S_PFIN: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_r[AW-1:0];
        occ_nxt   = occ_r + ONE;
        state_nxt = S_DONE;
      end

      S_QHEAD: begin
        res_data_nxt = mem_rdata;
        if (occ_r == ONE) begin
          occ_nxt   = occ_m1;
          state_nxt = S_DONE;
        end else begin
          mem_raddr = cnt_r[AW-1:0];
          state_nxt = S_QSHIFT;
        end
      end

      S_QSHIFT: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_m1[AW-1:0];
        mem_wdata = mem_rdata;
        if (cnt_r == occ_m1) begin
          occ_nxt   = occ_m1;
          state_nxt = S_DONE;
        end else begin
          cnt_nxt   = cnt_p1;
          mem_raddr = cnt_p1[AW-1:0];
        end
      end

      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_stat_nxt  = res_stat_r;
          out_data_nxt  = res_data_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r      <= cnt_nxt;
    item_r     <= item_nxt;
    res_stat_r <= res_stat_nxt;
    res_data_r <= res_data_nxt;
    out_stat_r <= out_stat_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_stat_r;

`ifndef SYNTHESIS
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= FULL_CNT)
    else $error("occupancy beyond queue depth");

  a_occ_step: assert property (@(posedge clk) disable iff (!rst_n)
    (occ_r != $past(occ_r)) |-> (occ_r == $past(occ_r) + ONE) ||
                                (occ_r == $past(occ_r) - ONE))
    else $error("occupancy moved by more than one");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser != ST_OK)) |-> (out_tdata == '0))
    else $error("refused beat carries entry data");

  a_full_refuse: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tuser == OP_PUSH) && (occ_r == FULL_CNT))
      |=> (occ_r == FULL_CNT) && (res_stat_r == ST_FULL))
    else $error("push into full queue not refused");
`endif

endmodule

// ===== tb/sapq_checker.sv =====
// ----------------------------------------------------------------------------
// sapq_checker: result predictor and scoreboard for the sorted-array queue
// Watches both stream channels, keeps its own sorted copy of the queue, works
// out the result of every accepted input beat and compares each result beat,
// field by field, with the oldest result still due.
// ----------------------------------------------------------------------------
module sapq_checker #(
  parameter int DEPTH = sapq_pkg::SAPQ_DEPTH
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  input  logic                         in_tready,
  input  logic [sapq_pkg::ENTRY_W-1:0] in_tdata,
  input  logic                         in_tuser,
  input  logic                         out_tvalid,
  input  logic                         out_tready,
  input  logic [sapq_pkg::ENTRY_W-1:0] out_tdata,
  input  logic [1:0]                   out_tuser,
  output int                           errors,
  output int                           outstanding,
  output int                           n_stored,
  output int                           n_refused,
  output int                           n_served,
  output int                           n_empty
);
  import sapq_pkg::*;

  localparam int REPORT_LIMIT = 40;

  typedef struct {
    status_t status;
    entry_t  item;
  } result_t;

  result_t due_results[$];
  entry_t  model_slots[DEPTH];
  int      model_count;

  function automatic bit served_first(entry_t a, entry_t b);
    if (a.prio != b.prio) return a.prio < b.prio;
    return a.key < b.key;
  endfunction

  task automatic predict_push(entry_t e);
    result_t r;
    int      pos;
    r.status = ST_OK;
    r.item   = '0;
    if (model_count >= DEPTH) begin
      r.status = ST_FULL;
      n_refused++;
    end else begin
      // Equal entries are not passed, so a newcomer queues behind its equals.
      pos = model_count;
      while (pos > 0 && served_first(e, model_slots[pos-1])) begin
        model_slots[pos] = model_slots[pos-1];
        pos--;
      end
      model_slots[pos] = e;
      model_count++;
      n_stored++;
    end
    due_results.push_back(r);
  endtask

  task automatic predict_pop();
    result_t r;
    r.status = ST_OK;
    r.item   = '0;
    if (model_count == 0) begin
      r.status = ST_EMPTY;
      n_empty++;
    end else begin
      r.item = model_slots[0];
      for (int i = 1; i < model_count; i++) model_slots[i-1] = model_slots[i];
      model_count--;
      n_served++;
    end
    due_results.push_back(r);
  endtask

  task automatic report(string what, longint unsigned want, longint unsigned got);
    errors++;
    if (errors <= REPORT_LIMIT)
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, want, got);
  endtask

  task automatic check_result(status_t st, entry_t e);
    result_t r;
    if (due_results.size() == 0) begin
      errors++;
      if (errors <= REPORT_LIMIT)
        $display("%0t: result beat with none due, expected nothing, got status %0d",
                 $time, st);
    end else begin
      r = due_results.pop_front();
      if (st !== r.status)
        report("status", 64'(r.status), 64'(st));
      if (e.tag !== r.item.tag)
        report("job tag", 64'(r.item.tag), 64'(e.tag));
      if (e.prio !== r.item.prio)
        report("priority", 64'(r.item.prio), 64'(e.prio));
      if (e.key !== r.item.key)
        report("order key", 64'(r.item.key), 64'(e.key));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      model_count = 0;
      due_results.delete();
    end else begin
      // The result side is taken first, so a stray beat is never matched
      // against an expectation raised at the same edge.
      if (out_tvalid && out_tready) check_result(out_tuser, entry_t'(out_tdata));
      if (in_tvalid && in_tready) begin
        if (in_tuser == OP_PUSH) predict_push(entry_t'(in_tdata));
        else predict_pop();
      end
    end
    outstanding <= due_results.size();
  end

endmodule

// ===== tb/tb_sorted_array_priority_queue.sv =====
// ----------------------------------------------------------------------------
// tb_sorted_array_priority_queue: stimulus and verdict for the priority queue
// A directed pass fills, overfills and empties the queue with ties and
// extreme values, then random push/pop traffic with drifting push bias runs
// under four sender/receiver idling patterns. Checking is done by sapq_checker.
// ----------------------------------------------------------------------------
module tb_sorted_array_priority_queue;
  import sapq_pkg::*;

  localparam int PHASE_ITEMS = 290;

  logic               clk        = 1'b0;
  logic               rst_n      = 1'b0;
  logic               in_tvalid  = 1'b0;
  logic               in_tready;
  logic [ENTRY_W-1:0] in_tdata   = '0;  // job_tag, priority_req, order_key
  logic               in_tuser   = OP_PUSH;  // op
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [ENTRY_W-1:0] out_tdata;  // out_job_tag, out_priority, out_order_key
  logic [1:0]         out_tuser;  // status

  int errors, outstanding, n_stored, n_refused, n_served, n_empty;
  int idle_pct  = 0;
  int stall_pct = 0;

  sorted_array_priority_queue uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  sapq_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .errors      (errors),
    .outstanding (outstanding),
    .n_stored    (n_stored),
    .n_refused   (n_refused),
    .n_served    (n_served),
    .n_empty     (n_empty)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    out_tready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
  end

  initial begin
    #800000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic entry_t make_entry(logic [TAG_W-1:0] tag, logic [PRIO_W-1:0] prio,
                                        logic [KEY_W-1:0] key);
    entry_t e;
    e.tag  = tag;
    e.prio = prio;
    e.key  = key;
    return e;
  endfunction

  // Narrow ranges most of the time so that ties are frequent.
  function automatic entry_t random_entry();
    entry_t e;
    e.tag = $urandom;
    case ($urandom_range(3))
      0:       e.prio = PRIO_W'($urandom_range(3));
      1:       e.prio = PRIO_W'($urandom);
      2:       e.prio = $urandom_range(1) ? '1 : '0;
      default: e.prio = PRIO_W'($urandom_range(15));
    endcase
    case ($urandom_range(2))
      0:       e.key = KEY_W'($urandom_range(3));
      1:       e.key = KEY_W'($urandom);
      default: e.key = $urandom_range(1) ? '1 : '0;
    endcase
    return e;
  endfunction

  // Valid stays high between back-to-back beats; it only drops for a gap.
  task automatic offer_beat(logic op, entry_t e);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= e;
    in_tuser  <= op;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic drain_queue();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  initial begin
    int push_pct;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty pop, fill with extremes and ties, overfill, empty out.
    offer_beat(OP_POP,  make_entry('1, '1, '1));
    offer_beat(OP_PUSH, make_entry('1, '1, '1));
    offer_beat(OP_PUSH, make_entry('0, '0, '0));
    offer_beat(OP_PUSH, make_entry(32'h0000_00A1, 16'd5, 8'd7));
    offer_beat(OP_PUSH, make_entry(32'h0000_00A2, 16'd5, 8'd7));
    offer_beat(OP_PUSH, make_entry(32'h0000_00A3, 16'd5, 8'd3));
    offer_beat(OP_PUSH, make_entry(32'h0000_00A4, 16'd5, 8'd7));
    offer_beat(OP_PUSH, make_entry(32'h0000_00A5, '1, '1));
    offer_beat(OP_PUSH, make_entry(32'h0000_00A6, '0, '0));
    offer_beat(OP_PUSH, make_entry(32'hDEAD_BEEF, 16'd1, 8'd1));
    for (int i = 0; i < 9; i++) offer_beat(OP_POP, make_entry('0, '0, '0));
    drain_queue();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 70; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 70; end
        default: begin idle_pct = 23; stall_pct = 23; end
      endcase
      push_pct = 50;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // The push bias drifts so the queue swings between full and empty.
        if (n % 16 == 0) begin
          case ($urandom_range(2))
            0:       push_pct = 15;
            1:       push_pct = 50;
            default: push_pct = 85;
          endcase
        end
        if ($urandom_range(99) < push_pct) offer_beat(OP_PUSH, random_entry());
        else offer_beat(OP_POP, random_entry());
      end
      drain_queue();
    end

    repeat (30) @(posedge clk);
    @(negedge clk);
    $display("Run covered %0d pushes stored, %0d refused as full, %0d pops served",
             n_stored, n_refused, n_served);
    $display("and %0d pops on an empty queue, under four idling patterns.", n_empty);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/sapq_pkg.sv
hdl/sapq_store.sv
hdl/sapq_cmp.sv
hdl/sorted_array_priority_queue.sv
tb/sapq_checker.sv
tb/tb_sorted_array_priority_queue.sv
